### design/mmi_pkg.sv
// shared types and constants for the monoclinic minimum-image pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mmi_pkg;

    localparam int CFG_NUM = 8;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CELL_A   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_B   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_H   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_A    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_B    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INV_H    = 3'd7;

    localparam int IN_W  = 192;
    localparam int OUT_W = 288;
    localparam int SQRT_STAGES = 16;   // two root bits per stage

    typedef struct packed {
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] image_x;
        logic signed [31:0] image_y;
        logic signed [31:0] image_z;
        logic [62:0]        dist_sq;
    } t_pay;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -33'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/monoclinic_minimum_image.sv
// monoclinic minimum-image separation, fully pipelined
// depends on mmi_pkg
`timescale 1ns / 1ps
`default_nettype none

// Takes one position pair per cycle and returns the minimum-image vector, the image of
// the first position nearest the second, the squared distance (saturating at 2^63-1)
// and its floor square root. Six arithmetic stages (difference, inverse-matrix multiply,
// wrap and cell multiply, sum and saturate, image and squares, square sum) are followed
// by sixteen square-root stages of two result bits each. One item per cycle is sustained;
// the whole pipe holds while a finished result waits and the last stage is full. The user
// must write cell registers only while the pipe is empty; the block does not enforce it.
module monoclinic_minimum_image
    import mmi_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [31:0]           i_cfg_data,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  wire [IN_W-1:0]       s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // vec_x, vec_y, vec_z, image_x, image_y, image_z, dist_sq, dist_res, one zero bit
    output logic [OUT_W-1:0]     m_axis_tdata
);

    logic signed [31:0] r_cfg [CFG_NUM];
    logic               en;
    logic [5:1]         r_vld;

    logic signed [32:0] r1_d [2][3];
    logic signed [31:0] r1_p2 [3];
    logic [29:0]        r2_f [2][4];
    logic signed [31:0] r2_p2 [3];
    logic signed [61:0] r3_r [2][4];
    logic signed [31:0] r3_p2 [3];
    logic signed [31:0] r4_v [2][3];
    logic signed [31:0] r4_p2 [3];
    logic signed [31:0] r5_v [3];
    logic signed [31:0] r5_img [3];
    logic [63:0]        r5_sq [3];

    logic [SQRT_STAGES:0]   r_sq_vld;
    logic [63:0]            r_sq_x   [SQRT_STAGES+1];
    logic [63:0]            r_sq_res [SQRT_STAGES+1];
    t_pay                   r_sq_pay [SQRT_STAGES+1];

    assign en = !r_sq_vld[SQRT_STAGES] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_CELL_A]  <= 32'sd65536;
            r_cfg[REG_CELL_B]  <= 32'sd65536;
            r_cfg[REG_CELL_SH] <= 32'sd0;
            r_cfg[REG_CELL_H]  <= 32'sd65536;
            r_cfg[REG_INV_A]   <= 32'sd1073741824;
            r_cfg[REG_INV_B]   <= 32'sd1073741824;
            r_cfg[REG_INV_SH]  <= 32'sd0;
            r_cfg[REG_INV_H]   <= 32'sd1073741824;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_sq_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[4:1], s_axis_tvalid};
            r_sq_vld <= {r_sq_vld[SQRT_STAGES-1:0], r_vld[5]};
        end
    end

    // stage 1: differences in both directions
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_d[0][i] <= $signed({s_axis_tdata[32*i+127], s_axis_tdata[32*i+96 +: 32]})
                            - $signed({s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]});
                r1_d[1][i] <= $signed({s_axis_tdata[32*i+31], s_axis_tdata[32*i +: 32]})
                            - $signed({s_axis_tdata[32*i+127], s_axis_tdata[32*i+96 +: 32]});
                r1_p2[i] <= s_axis_tdata[32*i+96 +: 32];
            end
        end
    end

    // stage 2: fractional terms; only the low 30 fraction bits survive the wrap
    logic signed [64:0] n2_p [2][4];
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n2_p[k][0] = r1_d[k][0] * r_cfg[REG_INV_A];
            n2_p[k][1] = r1_d[k][1] * r_cfg[REG_INV_B];
            n2_p[k][2] = r1_d[k][2] * r_cfg[REG_INV_SH];
            n2_p[k][3] = r1_d[k][2] * r_cfg[REG_INV_H];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 2; k++) begin
                for (int j = 0; j < 4; j++) begin
                    r2_f[k][j] <= n2_p[k][j][45:16];
                end
            end
            r2_p2 <= r1_p2;
        end
    end

    // stage 3: wrap to [-1/2, 1/2) and multiply by the cell matrix
    logic [29:0]        n3_u [2][3];
    logic signed [29:0] n3_w [2][3];
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n3_u[k][0] = r2_f[k][0] + 30'h2000_0000;
            n3_u[k][1] = r2_f[k][1] + r2_f[k][2] + 30'h2000_0000;
            n3_u[k][2] = r2_f[k][3] + 30'h2000_0000;
            for (int i = 0; i < 3; i++) begin
                n3_w[k][i] = {~n3_u[k][i][29], n3_u[k][i][28:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 2; k++) begin
                r3_r[k][0] <= n3_w[k][0] * r_cfg[REG_CELL_A];
                r3_r[k][1] <= n3_w[k][1] * r_cfg[REG_CELL_B];
                r3_r[k][2] <= n3_w[k][2] * r_cfg[REG_CELL_SH];
                r3_r[k][3] <= n3_w[k][2] * r_cfg[REG_CELL_H];
            end
            r3_p2 <= r2_p2;
        end
    end

    // stage 4: y-row sum, floor by 2^30 and saturate
    logic signed [62:0] n4_ys [2];
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            n4_ys[k] = 63'(r3_r[k][1]) + 63'(r3_r[k][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 2; k++) begin
                r4_v[k][0] <= r3_r[k][0][61:30];
                r4_v[k][1] <= sat33(n4_ys[k][62:30]);
                r4_v[k][2] <= r3_r[k][3][61:30];
            end
            r4_p2 <= r3_p2;
        end
    end

    // stage 5: image and squares
    logic [31:0] n5_abs [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_abs[i] = r4_v[0][i][31] ? 32'(-r4_v[0][i]) : 32'(r4_v[0][i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r5_v[i]   <= r4_v[0][i];
                r5_img[i] <= sat33(33'(r4_v[1][i]) + 33'(r4_p2[i]));
                r5_sq[i]  <= n5_abs[i] * n5_abs[i];
            end
        end
    end

    // stage 6: squared distance, saturated, enters the root pipe
    logic [65:0] n6_sum;
    logic [62:0] n6_dsq;
    assign n6_sum = 66'(r5_sq[0]) + 66'(r5_sq[1]) + 66'(r5_sq[2]);
    assign n6_dsq = (n6_sum[65:63] != 3'd0) ? {63{1'b1}} : n6_sum[62:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_x[0]           <= {1'b0, n6_dsq};
            r_sq_res[0]         <= '0;
            r_sq_pay[0].vec_x   <= r5_v[0];
            r_sq_pay[0].vec_y   <= r5_v[1];
            r_sq_pay[0].vec_z   <= r5_v[2];
            r_sq_pay[0].image_x <= r5_img[0];
            r_sq_pay[0].image_y <= r5_img[1];
            r_sq_pay[0].image_z <= r5_img[2];
            r_sq_pay[0].dist_sq <= n6_dsq;
        end
    end

    // restoring square root, two result bits per stage
    for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
        logic [63:0] n_x;
        logic [63:0] n_res;
        always_comb begin
            logic [63:0] x;
            logic [63:0] res;
            logic [63:0] bitv;
            x = r_sq_x[g];
            res = r_sq_res[g];
            for (int s = 0; s < 2; s++) begin
                bitv = 64'd1 << (62 - 2 * (2 * g + s));
                if (x >= res + bitv) begin
                    x = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
            end
            n_x = x;
            n_res = res;
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_x[g+1]   <= n_x;
                r_sq_res[g+1] <= n_res;
                r_sq_pay[g+1] <= r_sq_pay[g];
            end
        end
    end

    assign m_axis_tvalid = r_sq_vld[SQRT_STAGES];
    assign m_axis_tdata  = {1'b0, r_sq_res[SQRT_STAGES][31:0],
                            r_sq_pay[SQRT_STAGES].dist_sq,
                            r_sq_pay[SQRT_STAGES].image_z,
                            r_sq_pay[SQRT_STAGES].image_y,
                            r_sq_pay[SQRT_STAGES].image_x,
                            r_sq_pay[SQRT_STAGES].vec_z,
                            r_sq_pay[SQRT_STAGES].vec_y,
                            r_sq_pay[SQRT_STAGES].vec_x};

endmodule

`default_nettype wire

### design/mmi_checker.sv
// port-level checks for monoclinic_minimum_image, bound to the top level
// depends on mmi_pkg
`timescale 1ns / 1ps
`default_nettype none

module mmi_checker
    import mmi_pkg::*;
(
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              s_axis_tready,
    input wire              m_axis_tvalid,
    input wire              m_axis_tready,
    input wire [OUT_W-1:0]  m_axis_tdata
);

    // a pending result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("pending result changed");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // input side only stalls behind a stalled result
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output stall");

    // padding bit stays clear
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !m_axis_tdata[OUT_W-1])
        else $error("padding bit set");

endmodule

bind monoclinic_minimum_image mmi_checker u_mmi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### sim/monoclinic_minimum_image_chk.sv
// checker for the monoclinic minimum-image pipeline: predicts each result and compares
// depends on mmi_pkg for the register indexes and port widths
`timescale 1ns / 1ps

module monoclinic_minimum_image_chk
    import mmi_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [31:0]       i_cfg_data,
    input  wire              i_req_valid,
    input  wire              i_req_ready,
    input  wire [IN_W-1:0]   i_req_data,
    input  wire              i_res_valid,
    input  wire              i_res_ready,
    input  wire [OUT_W-1:0]  i_res_data,
    output int               o_errors,
    output int               o_pending
);

    typedef struct {
        logic signed [31:0] vec [3];
        logic signed [31:0] img [3];
        logic [62:0]        dsq;
        logic [31:0]        droot;
    } t_sep;

    logic signed [63:0] cell_mat [CFG_NUM];
    t_sep separations [$];

    function automatic logic signed [63:0] asr(input logic signed [127:0] v, input int s);
        logic signed [127:0] t;
        t = v >>> s;
        return t[63:0];
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // wrap a Q.30 fraction to [-1/2, 1/2)
    function automatic logic signed [63:0] wrap_q30(input logic signed [63:0] f);
        logic [63:0] u;
        u = f + 64'sd536870912;
        return $signed({34'd0, u[29:0]}) - 64'sd536870912;
    endfunction

    function automatic string axis_name(input int i);
        case (i)
            0: return "x";
            1: return "y";
            default: return "z";
        endcase
    endfunction

    function automatic void nearest_image(input logic signed [63:0] d [3],
                                          output logic signed [63:0] r [3]);
        logic signed [63:0] fx, fy, fz, wx, wy, wz;
        fx = asr(128'(d[0]) * 128'(cell_mat[REG_INV_A]), 16);
        fy = asr(128'(d[1]) * 128'(cell_mat[REG_INV_B]), 16)
           + asr(128'(d[2]) * 128'(cell_mat[REG_INV_SH]), 16);
        fz = asr(128'(d[2]) * 128'(cell_mat[REG_INV_H]), 16);
        wx = wrap_q30(fx);
        wy = wrap_q30(fy);
        wz = wrap_q30(fz);
        r[0] = clamp32(asr(128'(wx) * 128'(cell_mat[REG_CELL_A]), 30));
        r[1] = clamp32(asr(128'(wy) * 128'(cell_mat[REG_CELL_B])
                         + 128'(wz) * 128'(cell_mat[REG_CELL_SH]), 30));
        r[2] = clamp32(asr(128'(wz) * 128'(cell_mat[REG_CELL_H]), 30));
    endfunction

    function automatic logic [31:0] floor_root(input logic [63:0] x);
        logic [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= res + bt) begin
                x = x - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res[31:0];
    endfunction

    function automatic t_sep predict_separation(input logic [IN_W-1:0] pair);
        logic signed [63:0] p1 [3], p2 [3], d [3], e [3], v [3], m [3];
        logic [64:0] sq;
        logic [63:0] a;
        t_sep s;
        for (int i = 0; i < 3; i++) begin
            p1[i] = 64'($signed(pair[32*i +: 32]));
            p2[i] = 64'($signed(pair[32*(i+3) +: 32]));
            d[i] = p2[i] - p1[i];
            e[i] = p1[i] - p2[i];
        end
        nearest_image(d, v);
        nearest_image(e, m);
        sq = 0;
        for (int i = 0; i < 3; i++) begin
            a = v[i] < 0 ? -v[i] : v[i];
            sq = sq + 65'(a * a);
            s.vec[i] = v[i][31:0];
            s.img[i] = 32'(clamp32(m[i] + p2[i]));
        end
        s.dsq = sq > 65'h7fffffffffffffff ? 63'h7fffffffffffffff : sq[62:0];
        s.droot = floor_root({1'b0, s.dsq});
        return s;
    endfunction

    assign o_pending = separations.size();

    always @(posedge i_clk) begin
        t_sep want;
        logic signed [31:0] got;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            cell_mat[REG_CELL_A] <= 65536;
            cell_mat[REG_CELL_B] <= 65536;
            cell_mat[REG_CELL_SH] <= 0;
            cell_mat[REG_CELL_H] <= 65536;
            cell_mat[REG_INV_A] <= 64'sd1073741824;
            cell_mat[REG_INV_B] <= 64'sd1073741824;
            cell_mat[REG_INV_SH] <= 0;
            cell_mat[REG_INV_H] <= 64'sd1073741824;
            separations.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we)
                cell_mat[i_cfg_idx] <= 64'($signed(i_cfg_data));
            if (i_req_valid && i_req_ready)
                separations.push_back(predict_separation(i_req_data));
            if (i_res_valid && i_res_ready) begin
                if (separations.size() == 0) begin
                    $error("unexpected result %h", i_res_data);
                    errs++;
                end else begin
                    want = separations.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        got = i_res_data[32*i +: 32];
                        if (got !== want.vec[i]) begin
                            $error("vec_%s expected %0d actual %0d", axis_name(i),
                                   want.vec[i], got);
                            errs++;
                        end
                        got = i_res_data[32*(i+3) +: 32];
                        if (got !== want.img[i]) begin
                            $error("image_%s expected %0d actual %0d", axis_name(i),
                                   want.img[i], got);
                            errs++;
                        end
                    end
                    if (i_res_data[192 +: 63] !== want.dsq) begin
                        $error("dist_sq expected %0d actual %0d", want.dsq,
                               i_res_data[192 +: 63]);
                        errs++;
                    end
                    if (i_res_data[255 +: 32] !== want.droot) begin
                        $error("dist_res expected %0d actual %0d", want.droot,
                               i_res_data[255 +: 32]);
                        errs++;
                    end
                end
            end
            o_errors <= o_errors + errs;
        end
    end

endmodule

### sim/monoclinic_minimum_image_tb.sv
// stimulus and verdict for the monoclinic minimum-image pipeline
// depends on mmi_pkg, monoclinic_minimum_image and monoclinic_minimum_image_chk
`timescale 1ns / 1ps

module monoclinic_minimum_image_tb;
    import mmi_pkg::*;

    localparam int DRAIN = 40;
    localparam int STALL_LIMIT = 5000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    int errors, pending;
    int send_idle_pct = 20;
    int recv_idle_pct = 48;
    bit hold_off = 1'b0;
    bit hold_armed = 1'b0;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    monoclinic_minimum_image dut (.*);

    monoclinic_minimum_image_chk chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready), .i_req_data(s_axis_tdata),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .i_res_data(m_axis_tdata),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // long receiver hold-off while requests keep coming, so the pipe fills and stalls
    initial begin
        wait (hold_armed);
        repeat (50) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (200) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("monoclinic_minimum_image_tb: errors");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
            3: return $urandom_range(0, 32'hffffff) - 32'h800000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_pair(input logic [IN_W-1:0] pair);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pair;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_cell(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    // cell terms then inverse terms, each in a, b, shear, h order; inverse terms in Q2.30 from cell terms in Q16.16
    task automatic load_cell(input logic [31:0] a, b, sh, h, ia, ib, ish, ih);
        write_cell(REG_CELL_A, a);
        write_cell(REG_CELL_B, b);
        write_cell(REG_CELL_SH, sh);
        write_cell(REG_CELL_H, h);
        write_cell(REG_INV_A, ia);
        write_cell(REG_INV_B, ib);
        write_cell(REG_INV_SH, ish);
        write_cell(REG_INV_H, ih);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_pairs(input int n);
        logic [IN_W-1:0] pair;
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < 6; i++) pair[32*i +: 32] = pick_coord();
            send_pair(pair);
        end
    endtask

    initial begin
        logic [IN_W-1:0] pair;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset cell, extremes, exact halves
        for (int k = 0; k < 12; k++) begin
            for (int i = 0; i < 6; i++) begin
                case (k)
                    0: pair[32*i +: 32] = 32'h7fffffff;
                    1: pair[32*i +: 32] = i < 3 ? 32'h80000000 : 32'h7fffffff;
                    2: pair[32*i +: 32] = i < 3 ? 32'h7fffffff : 32'h80000000;
                    3: pair[32*i +: 32] = i < 3 ? 0 : 32'h8000;
                    4: pair[32*i +: 32] = i < 3 ? 32'h8000 : 0;
                    5: pair[32*i +: 32] = 0;
                    6: pair[32*i +: 32] = i < 3 ? 32'h18000 : 0;
                    default: pair[32*i +: 32] = pick_coord();
                endcase
            end
            send_pair(pair);
        end
        drain();

        // extreme registers, saturating everything
        load_cell(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        for (int k = 0; k < 8; k++) begin
            for (int i = 0; i < 6; i++)
                pair[32*i +: 32] = k[0] ? (i < 3 ? 32'h80000000 : 32'h7fffffff) : pick_coord();
            send_pair(pair);
        end
        drain();

        load_cell(32'h000a0000, 32'h000c0000, 32'h00030000, 32'h00080000,
                  32'h06666666, 32'h05555555, 32'hfe555556, 32'h08000000);
        hold_armed = 1'b1;
        random_pairs(600);
        drain();

        // sender idles more often than the receiver
        send_idle_pct = 48;
        recv_idle_pct = 20;
        load_cell($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
        random_pairs(300);
        drain();
        load_cell(32'h00020000, 32'h00018000, 32'hffff0000, 32'h00040000,
                  32'h20000000, 32'h2aaaaaab, 32'h0aaaaaab, 32'h10000000);
        random_pairs(300);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_cell(32'h00010000, 32'h00010000, 32'h0, 32'h00010000,
                  32'h40000000, 32'h40000000, 32'h0, 32'h40000000);
        random_pairs(330);
        drain();
        load_cell(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        random_pairs(300);
        drain();

        if (errors == 0)
            $display("monoclinic_minimum_image_tb: clean");
        else
            $display("monoclinic_minimum_image_tb: errors");
        $finish;
    end

endmodule
